// ----- rtl/arm_pkg.sv -----
// Shared types and constants for the address range tag remapper.
package arm_pkg;

	localparam logic [63:0] REMAP_MARKER = 64'h0a00_0000_0000_0000;
	localparam int unsigned TABLE_SHIFT  = 52;
	localparam int unsigned COLUMN_SHIFT = 48;

	// Item action codes.
	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	// One queued word as it passes from the front to the back.
	typedef struct packed {
		action_t     action;
		logic [63:0] address;
		logic [31:0] region_size;
		logic [7:0]  table_tag;
		logic [7:0]  column_tag;
	} item_t;

	// Queue handshake between front and back.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

// ----- rtl/arm_front.sv -----
// Front end: accepts words and holds them in a two-word queue for the back end.
module arm_front import arm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        action,
	input  logic [63:0] address,
	input  logic [31:0] region_size,
	input  logic [7:0]  table_tag,
	input  logic [7:0]  column_tag,
	output logic        busy,
	output queue_out_t  q_out,
	input  logic        q_pop
);

	item_t      slot_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      in_item;

	// Classify the incoming word by its action bit.
	always_comb begin
		in_item.action      = action ? ACT_LOOKUP : ACT_INSERT;
		in_item.address     = address;
		in_item.region_size = region_size;
		in_item.table_tag   = table_tag;
		in_item.column_tag  = column_tag;
	end

	assign busy  = (count_q == 2'd2);
	assign push  = start && !busy;
	assign pop   = q_pop && (count_q != 2'd0);
	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item  = slot_q[rd_ptr_q];

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/arm_back.sv -----
// Back end: scans the region table for each queued word and produces its result.
module arm_back import arm_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_out_t  q_in,
	output logic        q_pop,
	output logic        done,
	output logic [63:0] mapped_address,
	output logic        hit,
	output logic        table_full
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q;
	item_t  cur_q;

	// Region table.
	logic [63:0] start_mem [ENTRIES];
	logic [63:0] end_mem   [ENTRIES];
	logic [7:0]  ttag_mem  [ENTRIES];
	logic [7:0]  ctag_mem  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             ent_vld_s1;
	logic [63:0]      start_s1;
	logic [63:0]      end_s1;
	logic [7:0]       ttag_s1;
	logic [7:0]       ctag_s1;

	// Scan accumulators.
	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             best_q;
	logic [63:0]      best_start_q;
	logic [63:0]      best_end_q;
	logic [7:0]       best_ttag_q;
	logic [7:0]       best_ctag_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             is_match;
	logic             is_free;
	logic             is_better;
	logic             lk_hit;

	assign q_pop = (state_q == ST_IDLE) && q_in.valid;

	// Compare the entry read last cycle against the current word.
	assign is_match  = rd_vld_s1 && ent_vld_s1 && (start_s1 == cur_q.address);
	assign is_free   = rd_vld_s1 && !ent_vld_s1;
	assign is_better = rd_vld_s1 && ent_vld_s1 && (start_s1 <= cur_q.address)
		&& (!best_q || (start_s1 > best_start_q));

	// Insert target: matching start first, then lowest free slot.
	assign wr_en  = (state_q == ST_FIN) && (cur_q.action == ACT_INSERT)
		&& (match_q || free_q);
	assign wr_idx = match_q ? match_idx_q : free_idx_q;
	assign lk_hit = best_q && (cur_q.address < best_end_q);

	// Table memory: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		start_s1 <= start_mem[rd_idx_q];
		end_s1   <= end_mem[rd_idx_q];
		ttag_s1  <= ttag_mem[rd_idx_q];
		ctag_s1  <= ctag_mem[rd_idx_q];
		if (wr_en) begin
			start_mem[wr_idx] <= cur_q.address;
			end_mem[wr_idx]   <= cur_q.address + {32'd0, cur_q.region_size};
			ttag_mem[wr_idx]  <= cur_q.table_tag;
			ctag_mem[wr_idx]  <= cur_q.column_tag;
		end
	end

	// Current word and result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_in.item;
		end
		if (state_q == ST_FIN) begin
			if (cur_q.action == ACT_INSERT) begin
				mapped_address <= 64'd0;
				hit            <= 1'b0;
				table_full     <= !(match_q || free_q);
			end else begin
				mapped_address <= lk_hit
					? (cur_q.address | REMAP_MARKER
						| ({56'd0, best_ttag_q} << TABLE_SHIFT)
						| ({56'd0, best_ctag_q} << COLUMN_SHIFT))
					: cur_q.address;
				hit            <= lk_hit;
				table_full     <= 1'b0;
			end
		end
		if (is_better) begin
			best_start_q <= start_s1;
			best_end_q   <= end_s1;
			best_ttag_q  <= ttag_s1;
			best_ctag_q  <= ctag_s1;
		end
		if (is_match && !match_q) begin
			match_idx_q <= rd_idx_s1;
		end
		if (is_free && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		rd_idx_s1 <= rd_idx_q;
	end

	// Sequencer, valid bits and scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			ent_vld_s1 <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			best_q     <= 1'b0;
			done       <= 1'b0;
		end else begin
			done       <= (state_q == ST_FIN);
			rd_vld_s1  <= (state_q == ST_SCAN);
			ent_vld_s1 <= valid_q[rd_idx_q];
			if (is_match) begin
				match_q <= 1'b1;
			end
			if (is_free) begin
				free_q <= 1'b1;
			end
			if (is_better) begin
				best_q <= 1'b1;
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					match_q  <= 1'b0;
					free_q   <= 1'b0;
					best_q   <= 1'b0;
					if (q_pop) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result strobe follows each finishing state.
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> done)
		else $error("result strobe missing after finish");

	// A result never reports both a hit and a dropped insert.
	a_hit_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && table_full))
		else $error("hit and table_full together");

	// Words are taken from the queue only when the sequencer is idle, and each one starts a scan.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_SCAN))
		else $error("pop without starting a scan");

	// An insert without a matching start finds a free slot unless every table entry is valid.
	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && cur_q.action == ACT_INSERT && !match_q)
		|-> (free_q || valid_q == '1))
		else $error("insert dropped with a free slot");

endmodule

// ----- rtl/address_range_tag_remapper.sv -----
// Top level of the address range tag remapper: front queue and table back end.
// A word waits in the queue, then passes scan, drain and finish before its done strobe.
// The back end pops a new word only when idle; its table scan reads one entry a cycle.
// A two-word queue lets start be taken while a scan runs; busy is high while it is full.
// Reset clears all region valid bits, the queue and the sequencer; results cannot be stalled.
module address_range_tag_remapper import arm_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [63:0] address,
	input  logic [31:0] region_size,
	input  logic [7:0]  table_tag,
	input  logic [7:0]  column_tag,
	output logic        done,
	output logic [63:0] mapped_address,
	output logic        hit,
	output logic        table_full
);

	queue_out_t q_link;
	logic       q_pop;

	// Front end with queue.
	arm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.address     (address),
		.region_size (region_size),
		.table_tag   (table_tag),
		.column_tag  (column_tag),
		.busy        (busy),
		.q_out       (q_link),
		.q_pop       (q_pop)
	);

	// Table scan back end.
	arm_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_in           (q_link),
		.q_pop          (q_pop),
		.done           (done),
		.mapped_address (mapped_address),
		.hit            (hit),
		.table_full     (table_full)
	);

endmodule
